// ===== sv/ifse_pkg.sv =====
package ifse_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [ByteW-1:0] byte_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG       = 3'd0,
    CFG_ESCAPE     = 3'd1,
    CFG_FLAG_SUB   = 3'd2,
    CFG_ESCAPE_SUB = 3'd3,
    CFG_ADDRESS    = 3'd4,
    CFG_CTRL_EVEN  = 3'd5,
    CFG_CTRL_ODD   = 3'd6
  } cfg_idx_t;

  // Register reset values
  localparam byte_t FlagReset      = 8'd126;
  localparam byte_t EscapeReset    = 8'd125;
  localparam byte_t FlagSubReset   = 8'd94;
  localparam byte_t EscapeSubReset = 8'd93;
  localparam byte_t AddressReset   = 8'd3;
  localparam byte_t CtrlEvenReset  = 8'd0;
  localparam byte_t CtrlOddReset   = 8'd64;

  // Emission phase of the held item
  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_HCHK,
    PH_DATA,
    PH_DATA2,
    PH_CHK,
    PH_CHK2,
    PH_CLOSE
  } phase_t;

endpackage

// ===== sv/info_frame_byte_stuffing_encoder.sv =====
// An accepted beat is held in the hold register; its first line byte is then registered
// into the output register before it shows on out_*. Each input beat yields 1 to 9
// line bytes, one per cycle while out_tready allows; the emission sequencer steps through
// the phases of the held item, and the next beat is taken in the cycle its last
// byte is emitted. rst_n (synchronous, active low) closes any open frame, clears the
// check and restores the register defaults.
module info_frame_byte_stuffing_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] payload_byte
  input  logic                        in_tuser,   // [0] seq_bit
  input  logic                        in_tlast,   // final_byte
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] line_byte
  output logic                        out_tuser,  // [0] frame_done
  output logic                        out_tlast,  // run_end
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ifse_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                  cfg_data
);

  ifse_pkg::byte_t flag_r, escape_r, flag_sub_r, escape_sub_r;
  ifse_pkg::byte_t address_r, ctrl_even_r, ctrl_odd_r;

  logic            in_frame_r;
  ifse_pkg::byte_t check_acc_r;

  logic            hold_valid_r;
  ifse_pkg::byte_t hold_byte_r;
  logic            hold_seq_r;
  logic            hold_last_r;
  ifse_pkg::byte_t hold_chk_r;
  ifse_pkg::phase_t phase_r, phase_nxt;

  logic            out_valid_r;
  ifse_pkg::byte_t out_byte_r, out_byte_nxt;
  logic            out_done_r, out_done_nxt;
  logic            out_end_r;

  logic            in_acc, emit, fin;
  ifse_pkg::byte_t acc_base, acc_new, ctrl_sel;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r       <= ifse_pkg::FlagReset;
      escape_r     <= ifse_pkg::EscapeReset;
      flag_sub_r   <= ifse_pkg::FlagSubReset;
      escape_sub_r <= ifse_pkg::EscapeSubReset;
      address_r    <= ifse_pkg::AddressReset;
      ctrl_even_r  <= ifse_pkg::CtrlEvenReset;
      ctrl_odd_r   <= ifse_pkg::CtrlOddReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ifse_pkg::CFG_FLAG:       flag_r       <= cfg_data;
        ifse_pkg::CFG_ESCAPE:     escape_r     <= cfg_data;
        ifse_pkg::CFG_FLAG_SUB:   flag_sub_r   <= cfg_data;
        ifse_pkg::CFG_ESCAPE_SUB: escape_sub_r <= cfg_data;
        ifse_pkg::CFG_ADDRESS:    address_r    <= cfg_data;
        ifse_pkg::CFG_CTRL_EVEN:  ctrl_even_r  <= cfg_data;
        ifse_pkg::CFG_CTRL_ODD:   ctrl_odd_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake control
  assign emit      = hold_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !hold_valid_r || (emit && fin);
  assign in_acc    = in_tvalid && in_tready;

  // Running check of the raw payload
  assign acc_base = in_frame_r ? check_acc_r : '0;
  assign acc_new  = acc_base ^ in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      check_acc_r <= '0;
    end else if (in_acc) begin
      in_frame_r  <= !in_tlast;
      check_acc_r <= in_tlast ? '0 : acc_new;
    end
  end

  // Held item and its emission phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      phase_r      <= ifse_pkg::PH_FLAG;
    end else if (in_acc) begin
      hold_valid_r <= 1'b1;
      phase_r      <= in_frame_r ? ifse_pkg::PH_DATA : ifse_pkg::PH_FLAG;
    end else if (emit) begin
      if (fin) begin
        hold_valid_r <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_byte_r <= in_tdata;
      hold_seq_r  <= in_tuser;
      hold_last_r <= in_tlast;
      hold_chk_r  <= acc_new;
    end
  end

  // Line byte selection per phase
  assign ctrl_sel = hold_seq_r ? ctrl_odd_r : ctrl_even_r;

  always_comb begin
    out_byte_nxt = flag_r;
    out_done_nxt = 1'b0;
    phase_nxt    = phase_r;
    fin          = 1'b0;
    unique case (phase_r)
      ifse_pkg::PH_FLAG: begin
        out_byte_nxt = flag_r;
        phase_nxt    = ifse_pkg::PH_ADDR;
      end
      ifse_pkg::PH_ADDR: begin
        out_byte_nxt = address_r;
        phase_nxt    = ifse_pkg::PH_CTRL;
      end
      ifse_pkg::PH_CTRL: begin
        out_byte_nxt = ctrl_sel;
        phase_nxt    = ifse_pkg::PH_HCHK;
      end
      ifse_pkg::PH_HCHK: begin
        out_byte_nxt = address_r ^ ctrl_sel;
        phase_nxt    = ifse_pkg::PH_DATA;
      end
      ifse_pkg::PH_DATA: begin
        if (hold_byte_r == flag_r || hold_byte_r == escape_r) begin
          out_byte_nxt = escape_r;
          phase_nxt    = ifse_pkg::PH_DATA2;
        end else begin
          out_byte_nxt = hold_byte_r;
          phase_nxt    = ifse_pkg::PH_CHK;
          fin          = !hold_last_r;
        end
      end
      ifse_pkg::PH_DATA2: begin
        out_byte_nxt = (hold_byte_r == flag_r) ? flag_sub_r : escape_sub_r;
        phase_nxt    = ifse_pkg::PH_CHK;
        fin          = !hold_last_r;
      end
      ifse_pkg::PH_CHK: begin
        if (hold_chk_r == flag_r || hold_chk_r == escape_r) begin
          out_byte_nxt = escape_r;
          phase_nxt    = ifse_pkg::PH_CHK2;
        end else begin
          out_byte_nxt = hold_chk_r;
          phase_nxt    = ifse_pkg::PH_CLOSE;
        end
      end
      ifse_pkg::PH_CHK2: begin
        out_byte_nxt = (hold_chk_r == flag_r) ? flag_sub_r : escape_sub_r;
        phase_nxt    = ifse_pkg::PH_CLOSE;
      end
      ifse_pkg::PH_CLOSE: begin
        out_byte_nxt = flag_r;
        out_done_nxt = 1'b1;
        fin          = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= out_byte_nxt;
      out_done_r <= out_done_nxt;
      out_end_r  <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_done_r;
  assign out_tlast  = out_end_r;

  // Closing flag always ends the run of its input beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame_done without run_end");

  // Check and close phases only for a final payload byte
  assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && (phase_r == ifse_pkg::PH_CHK || phase_r == ifse_pkg::PH_CHK2 ||
                     phase_r == ifse_pkg::PH_CLOSE) |-> hold_last_r)
    else $error("check phase on a non-final byte");

  // An accepted beat is held in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> hold_valid_r)
    else $error("accepted beat not held");

  // Frame closes exactly when the final byte is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_frame_r && check_acc_r == '0)
    else $error("frame state not cleared after final byte");

endmodule

// ===== tb/tb_info_frame_byte_stuffing_encoder.sv =====
module tb_info_frame_byte_stuffing_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ifse_pkg::CfgIdxW-1:0] reg_sel_t;

  // Register index that maps to no register; writes to it must be dropped
  localparam reg_sel_t CfgNoReg = 3'd7;
  localparam int unsigned RandBeats = 100;

  typedef struct packed {
    ifse_pkg::byte_t line_byte;
    logic            frame_done;
    logic            run_end;
  } line_beat_t;

  // Shadow of the framer: registers, open-frame flag, running XOR and the
  // line bytes still owed by the block
  class framed_line_predictor;
    ifse_pkg::byte_t flag_val, esc_val, flag_sub, esc_sub;
    ifse_pkg::byte_t addr_val, ctrl_even, ctrl_odd;
    bit              frame_open;
    ifse_pkg::byte_t running_xor;
    line_beat_t      pending[$];
    line_beat_t      beat_lines[$];
    int              mismatches;

    function new();
      flag_val    = ifse_pkg::FlagReset;
      esc_val     = ifse_pkg::EscapeReset;
      flag_sub    = ifse_pkg::FlagSubReset;
      esc_sub     = ifse_pkg::EscapeSubReset;
      addr_val    = ifse_pkg::AddressReset;
      ctrl_even   = ifse_pkg::CtrlEvenReset;
      ctrl_odd    = ifse_pkg::CtrlOddReset;
      frame_open  = 1'b0;
      running_xor = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(reg_sel_t idx, ifse_pkg::byte_t v);
      case (idx)
        ifse_pkg::CFG_FLAG:       flag_val  = v;
        ifse_pkg::CFG_ESCAPE:     esc_val   = v;
        ifse_pkg::CFG_FLAG_SUB:   flag_sub  = v;
        ifse_pkg::CFG_ESCAPE_SUB: esc_sub   = v;
        ifse_pkg::CFG_ADDRESS:    addr_val  = v;
        ifse_pkg::CFG_CTRL_EVEN:  ctrl_even = v;
        ifse_pkg::CFG_CTRL_ODD:   ctrl_odd  = v;
        default: ;
      endcase
    endfunction

    function void push_line(ifse_pkg::byte_t b, logic done);
      line_beat_t lb;
      lb.line_byte  = b;
      lb.frame_done = done;
      lb.run_end    = 1'b0;
      beat_lines.push_back(lb);
    endfunction

    // flag match wins when flag and escape share a value
    function void push_stuffed(ifse_pkg::byte_t b);
      if (b == flag_val) begin
        push_line(esc_val, 1'b0);
        push_line(flag_sub, 1'b0);
      end else if (b == esc_val) begin
        push_line(esc_val, 1'b0);
        push_line(esc_sub, 1'b0);
      end else begin
        push_line(b, 1'b0);
      end
    endfunction

    function void take_payload(ifse_pkg::byte_t data, logic seq, logic is_final);
      ifse_pkg::byte_t ctrl;
      line_beat_t      tail;
      beat_lines = {};
      // opening header goes out unstuffed
      if (!frame_open) begin
        ctrl = seq ? ctrl_odd : ctrl_even;
        push_line(flag_val, 1'b0);
        push_line(addr_val, 1'b0);
        push_line(ctrl, 1'b0);
        push_line(addr_val ^ ctrl, 1'b0);
        frame_open  = 1'b1;
        running_xor = '0;
      end
      push_stuffed(data);
      running_xor ^= data;
      if (is_final) begin
        push_stuffed(running_xor);
        push_line(flag_val, 1'b1);
        frame_open  = 1'b0;
        running_xor = '0;
      end
      tail = beat_lines[beat_lines.size()-1];
      tail.run_end = 1'b1;
      beat_lines[beat_lines.size()-1] = tail;
      foreach (beat_lines[i]) pending.push_back(beat_lines[i]);
    endfunction

    function void match_line_byte(ifse_pkg::byte_t b, logic done, logic rend);
      line_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected line beat, actual byte %h done %b end %b",
                 $time, b, done, rend);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (b !== want.line_byte) begin
        $display("%0t: line_byte expected %h actual %h", $time, want.line_byte, b);
        mismatches++;
      end
      if (done !== want.frame_done) begin
        $display("%0t: frame_done expected %b actual %b", $time, want.frame_done, done);
        mismatches++;
      end
      if (rend !== want.run_end) begin
        $display("%0t: run_end expected %b actual %b", $time, want.run_end, rend);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  reg_sel_t             cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;

  framed_line_predictor line_pred = new();
  int unsigned          burst_left = 0;
  logic [7:0]           rx_cycle   = '0;

  info_frame_byte_stuffing_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: stall pattern changes with the top two bits of rx_cycle
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    case (rx_cycle[7:6])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (rx_cycle[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(0, 6) != 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      line_pred.match_line_byte(out_tdata, out_tuser, out_tlast);
  end

  // One payload beat; bursts of random length with random gaps between them
  task automatic send_beat(input ifse_pkg::byte_t data, input logic seq,
                           input logic is_final);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= seq;
    in_tlast  <= is_final;
    do @(posedge clk); while (!in_tready);
    line_pred.take_payload(data, seq, is_final);
  endtask

  // seq is only sampled on the first beat, so later beats carry noise there
  task automatic send_frame(input ifse_pkg::byte_t data_q[$], input logic seq,
                            input logic close);
    foreach (data_q[i])
      send_beat(data_q[i], (i == 0) ? seq : logic'($urandom_range(0, 1)),
                close && (i == data_q.size() - 1));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (line_pred.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Config beats back to back; valid drops once after the last one
  task automatic apply_regs(input reg_sel_t idx_q[$], input ifse_pkg::byte_t val_q[$]);
    foreach (idx_q[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_q[i];
      cfg_data  <= val_q[i];
      do @(posedge clk); while (!cfg_ready);
      line_pred.write_reg(idx_q[i], val_q[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all(input ifse_pkg::byte_t val_q[$]);
    reg_sel_t idx_q[$];
    for (int i = 0; i < 7; i++) idx_q.push_back(reg_sel_t'(i));
    apply_regs(idx_q, val_q);
  endtask

  function automatic ifse_pkg::byte_t pick_payload();
    case ($urandom_range(0, 9))
      0: return line_pred.flag_val;
      1: return line_pred.esc_val;
      2: return 8'h00;
      3: return 8'hFF;
      default: return ifse_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic ifse_pkg::byte_t pick_reg_value();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return line_pred.flag_val;
      3: return line_pred.esc_val;
      default: return ifse_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned     rand_sent;
    int unsigned     len;
    ifse_pkg::byte_t frame_q[$];
    reg_sel_t        idx_q[$];
    ifse_pkg::byte_t val_q[$];

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: plain, flag and escape payload, check byte that needs stuffing
    send_frame('{8'h00, 8'h7E, 8'h7D, 8'hFF}, 1'b0, 1'b1);
    send_frame('{8'h7E}, 1'b1, 1'b1);
    send_frame('{8'h7D}, 1'b0, 1'b1);

    // escape moved while a frame is open, plus a write to the unmapped index
    send_frame('{8'h5A}, 1'b1, 1'b0);
    drain_results();
    apply_regs('{ifse_pkg::CFG_ESCAPE, CfgNoReg}, '{8'h5A, 8'h55});
    send_frame('{8'h5A, 8'h00}, 1'b0, 1'b1);
    drain_results();

    // flag equal to escape; header bytes colliding with both go out raw
    load_all('{8'h5A, 8'h5A, 8'h01, 8'h02, 8'h5A, 8'h5A, 8'h00});
    send_frame('{8'h5A, 8'h5A}, 1'b0, 1'b1);
    send_frame('{8'h5A}, 1'b1, 1'b1);
    drain_results();

    // all registers at the low extreme, then the high one
    load_all('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_frame('{8'h00, 8'hFF}, 1'b1, 1'b1);
    drain_results();
    load_all('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_frame('{8'hFF, 8'h00, 8'h80}, 1'b0, 1'b1);
    drain_results();
    load_all('{ifse_pkg::FlagReset, ifse_pkg::EscapeReset, ifse_pkg::FlagSubReset,
               ifse_pkg::EscapeSubReset, ifse_pkg::AddressReset,
               ifse_pkg::CtrlEvenReset, ifse_pkg::CtrlOddReset});

    // random phases: reconfigure while idle, then a handful of frames
    rand_sent = 0;
    while (rand_sent < RandBeats) begin
      drain_results();
      idx_q = {};
      val_q = {};
      for (int i = 0; i < 7; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          idx_q.push_back(reg_sel_t'(i));
          val_q.push_back(pick_reg_value());
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        idx_q.push_back(CfgNoReg);
        val_q.push_back(ifse_pkg::byte_t'($urandom_range(0, 255)));
      end
      apply_regs(idx_q, val_q);
      repeat ($urandom_range(2, 6)) begin
        frame_q = {};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
        repeat (len) frame_q.push_back(pick_payload());
        send_frame(frame_q, logic'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
        rand_sent += len;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (line_pred.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ifse_pkg.sv
sv/info_frame_byte_stuffing_encoder.sv
tb/tb_info_frame_byte_stuffing_encoder.sv
